// ===== hdl/lr_pkg.sv =====
// Shared constants, item types and queue command type for the line rasterizer.
package lr_pkg;

  localparam int unsigned SCREEN_WIDTH  = 640;
  localparam int unsigned SCREEN_HEIGHT = 480;

  localparam int unsigned COORD_W = 12;
  localparam int unsigned X_W     = 10;
  localparam int unsigned Y_W     = 9;
  localparam int unsigned ADDR_W  = 19;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned ERR_W   = 12;
  localparam int unsigned STEP_W  = 2;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } lr_op_e;

  typedef struct packed {
    lr_op_e                     operation;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  end_y;
    logic [COLOR_W-1:0]         color;
  } lr_in_t;

  typedef struct packed {
    logic [X_W-1:0]     pixel_x;
    logic [Y_W-1:0]     pixel_y;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] shade;
    logic               last;
  } lr_out_t;

  // Classified item as it sits in the queue
  typedef struct packed {
    lr_op_e                    op;
    logic [X_W-1:0]            x0;
    logic [Y_W-1:0]            y0;
    logic [X_W-1:0]            major;
    logic [X_W-1:0]            minor;
    logic signed [STEP_W-1:0]  x_step;
    logic signed [STEP_W-1:0]  y_step;
    logic                      swapped;
    logic [COLOR_W-1:0]        color;
  } lr_cmd_t;

  typedef struct packed {
    logic busy;
    logic load;
    logic fin;
  } lr_back_status_t;

endpackage

// ===== hdl/line_rasterizer.sv =====
// Top level of the line rasterizer: front end, command queue and stepping back end.
// A step item passes through the queue and then the output register before its pixel shows at the output.
// Throughput: one item per clock while the queue is not full; each step item yields at most one pixel.
// The queue holds two classified items; input stalls only when it is full.
// The output register reloads on the edge it is taken; a held pixel keeps the next step queued while a line is armed.
// Reset (asynchronous, active low) empties the queue and output, and leaves no line armed.
module line_rasterizer import lr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  lr_in_t  in_item_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output lr_out_t out_item_o
);

  // front -> queue
  logic    q_push, q_full;
  lr_cmd_t front_cmd;

  // queue -> back
  logic    q_pop, q_empty;
  lr_cmd_t q_cmd;

  lr_back_status_t back_st;

  // Clamping, deltas, signs and the steep-line swap are settled here, so the
  // back end only ever sees ready-made setup values.
  lr_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (front_cmd)
  );

  // Decouples input acceptance from output back-pressure.
  lr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd)
  );

  // Start items arm the engine; step items while idle are simply dropped.
  // A step for an armed line only leaves the queue when the output register can take its pixel.
  lr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .cmd_i       (q_cmd),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .status_o    (back_st)
  );

  // Frame-buffer offset must always agree with the emitted coordinates
  a_addr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.pixel_address ==
      ADDR_W'(out_item_o.pixel_y) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(out_item_o.pixel_x))
    else $error("pixel address does not match coordinates");

  // Stepping never walks off the screen
  a_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.pixel_x <= X_W'(SCREEN_WIDTH - 1)) &&
                    (out_item_o.pixel_y <= Y_W'(SCREEN_HEIGHT - 1)))
    else $error("pixel outside screen");

  // A new pixel must never overwrite one that is still held by back-pressure
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.load |-> !(out_valid_o && out_stall_i))
    else $error("output register overwritten while stalled");

  // A last pixel ends the line: the engine is idle on the next cycle
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.load && back_st.fin |=> !back_st.busy)
    else $error("engine still busy after last pixel");

endmodule

// ===== hdl/lr_front.sv =====
// Front end: accepts items, clamps endpoints and works out deltas, signs and axis swap.
module lr_front import lr_pkg::*; (
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  lr_in_t  in_item_i,
  input  logic    q_full_i,
  output logic    push_o,
  output lr_cmd_t cmd_o
);

  function automatic logic [X_W-1:0] clamp_x(input logic signed [COORD_W-1:0] v);
    logic [X_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(COORD_W'(SCREEN_WIDTH - 1))) begin
      r = X_W'(SCREEN_WIDTH - 1);
    end else begin
      r = v[X_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [Y_W-1:0] clamp_y(input logic signed [COORD_W-1:0] v);
    logic [Y_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(COORD_W'(SCREEN_HEIGHT - 1))) begin
      r = Y_W'(SCREEN_HEIGHT - 1);
    end else begin
      r = v[Y_W-1:0];
    end
    return r;
  endfunction

  logic [X_W-1:0] x1, x2, dx;
  logic [Y_W-1:0] y1, y2, dy;
  logic signed [STEP_W-1:0] sx, sy;
  logic steep;

  // no state here; the front only stalls on a full queue
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    x1 = clamp_x(in_item_i.start_x);
    x2 = clamp_x(in_item_i.end_x);
    y1 = clamp_y(in_item_i.start_y);
    y2 = clamp_y(in_item_i.end_y);

    if (x2 < x1) begin
      dx = x1 - x2;
      sx = -STEP_W'(1);
    end else begin
      dx = x2 - x1;
      sx = (x2 == x1) ? STEP_W'(0) : STEP_W'(1);
    end

    if (y2 < y1) begin
      dy = y1 - y2;
      sy = -STEP_W'(1);
    end else begin
      dy = y2 - y1;
      sy = (y2 == y1) ? STEP_W'(0) : STEP_W'(1);
    end

    steep = X_W'(dy) > dx;

    cmd_o.op      = in_item_i.operation;
    cmd_o.x0      = x1;
    cmd_o.y0      = y1;
    cmd_o.major   = steep ? X_W'(dy) : dx;
    cmd_o.minor   = steep ? dx : X_W'(dy);
    cmd_o.x_step  = sx;
    cmd_o.y_step  = sy;
    cmd_o.swapped = steep;
    cmd_o.color   = in_item_i.color;
  end

endmodule

// ===== hdl/lr_queue.sv =====
// Short command queue between front and back end.
module lr_queue import lr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  lr_cmd_t cmd_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output lr_cmd_t cmd_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  lr_cmd_t            slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/lr_back.sv =====
// Back end: Bresenham stepping engine and registered pixel output.
module lr_back import lr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  lr_cmd_t         cmd_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lr_out_t         out_item_o,
  output lr_back_status_t status_o
);

  localparam int unsigned EW = ERR_W + 1;

  logic [X_W-1:0]           cur_x_q, cur_x_d;
  logic [Y_W-1:0]           cur_y_q, cur_y_d;
  logic [ERR_W-1:0]         err_q, err_d;
  logic [X_W-1:0]           major_q, major_d;
  logic [X_W-1:0]           minor_q, minor_d;
  logic signed [STEP_W-1:0] xs_q, xs_d, ys_q, ys_d;
  logic                     swapped_q, swapped_d;
  logic [X_W-1:0]           left_q, left_d;
  logic [COLOR_W-1:0]       color_q, color_d;
  logic                     busy_q, busy_d;
  logic                     out_valid_q, out_valid_d;
  lr_out_t                  out_q, out_d;

  logic           can_emit, load, fin, err_ge;
  logic [EW-1:0]  err_ext, err_next;
  logic [X_W-1:0] x_inc;
  logic [Y_W-1:0] y_inc;

  assign can_emit = !out_valid_q || !out_stall_i;
  assign pop_o    = !empty_i && ((cmd_i.op == OP_START) || !busy_q || can_emit);
  assign load     = pop_o && (cmd_i.op == OP_STEP) && busy_q;
  assign fin      = (left_q <= X_W'(1));
  assign err_ge   = !err_q[ERR_W-1];
  assign x_inc    = {{(X_W-STEP_W){xs_q[STEP_W-1]}}, xs_q};
  assign y_inc    = {{(Y_W-STEP_W){ys_q[STEP_W-1]}}, ys_q};
  assign err_ext  = {err_q[ERR_W-1], err_q};

  // err - (err >= 0 ? 2*major : 0) + 2*minor, modulo EW bits
  assign err_next = err_ext - (err_ge ? EW'({major_q, 1'b0}) : EW'(0))
                  + EW'({minor_q, 1'b0});

  always_comb begin
    out_d.pixel_x       = cur_x_q;
    out_d.pixel_y       = cur_y_q;
    out_d.pixel_address = ADDR_W'(cur_y_q) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(cur_x_q);
    out_d.shade         = color_q;
    out_d.last          = fin;
  end

  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    err_d     = err_q;
    major_d   = major_q;
    minor_d   = minor_q;
    xs_d      = xs_q;
    ys_d      = ys_q;
    swapped_d = swapped_q;
    left_d    = left_q;
    color_d   = color_q;
    busy_d    = busy_q;

    if (pop_o) begin
      unique case (cmd_i.op)
        OP_START: begin
          cur_x_d   = cmd_i.x0;
          cur_y_d   = cmd_i.y0;
          major_d   = cmd_i.major;
          minor_d   = cmd_i.minor;
          xs_d      = cmd_i.x_step;
          ys_d      = cmd_i.y_step;
          swapped_d = cmd_i.swapped;
          color_d   = cmd_i.color;
          err_d     = ERR_W'(EW'({cmd_i.minor, 1'b0}) - EW'(cmd_i.major));
          left_d    = cmd_i.major + X_W'(1);
          busy_d    = 1'b1;
        end
        OP_STEP: begin
          if (busy_q) begin
            if (fin) begin
              busy_d = 1'b0;
              left_d = '0;
            end else begin
              if (swapped_q) begin
                cur_y_d = cur_y_q + y_inc;
                if (err_ge) cur_x_d = cur_x_q + x_inc;
              end else begin
                cur_x_d = cur_x_q + x_inc;
                if (err_ge) cur_y_d = cur_y_q + y_inc;
              end
              err_d  = err_next[ERR_W-1:0];
              left_d = left_q - X_W'(1);
            end
          end
        end
        default: ;
      endcase
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      err_q       <= '0;
      major_q     <= '0;
      minor_q     <= '0;
      xs_q        <= '0;
      ys_q        <= '0;
      swapped_q   <= 1'b0;
      left_q      <= '0;
      color_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      err_q       <= err_d;
      major_q     <= major_d;
      minor_q     <= minor_d;
      xs_q        <= xs_d;
      ys_q        <= ys_d;
      swapped_q   <= swapped_d;
      left_q      <= left_d;
      color_q     <= color_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_item_o    = out_q;
  assign status_o.busy = busy_q;
  assign status_o.load = load;
  assign status_o.fin  = fin;

endmodule
